/* rtl/dsky_relay_word_display_decoder_macros.svh */
// Assertion helpers used by the checker of the display decoder.
`ifndef DSKY_RELAY_WORD_DISPLAY_DECODER_MACROS_SVH
`define DSKY_RELAY_WORD_DISPLAY_DECODER_MACROS_SVH

// Checked at every clock edge outside reset.
`define DSKY_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DSKY_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dsky_pkg.sv */
package dsky_pkg;

	typedef logic [3:0] char_t;
	typedef logic [1:0] sign_t;
	typedef logic [3:0] relay_t;

	localparam char_t BLANK_CH = 4'd15;

	localparam sign_t SIGN_BLANK = 2'd0;
	localparam sign_t SIGN_PLUS  = 2'd1;
	localparam sign_t SIGN_MINUS = 2'd2;

	localparam relay_t RELAY_R3_LO  = 4'd1;
	localparam relay_t RELAY_R3_HI  = 4'd2;
	localparam relay_t RELAY_R2R3   = 4'd3;
	localparam relay_t RELAY_R2_LO  = 4'd4;
	localparam relay_t RELAY_R2_HI  = 4'd5;
	localparam relay_t RELAY_R1_LO  = 4'd6;
	localparam relay_t RELAY_R1_MID = 4'd7;
	localparam relay_t RELAY_R1_TOP = 4'd8;
	localparam relay_t RELAY_NOUN   = 4'd9;
	localparam relay_t RELAY_VERB   = 4'd10;
	localparam relay_t RELAY_PROG   = 4'd11;

	localparam logic [7:0]  PAIR_BLANK = {BLANK_CH, BLANK_CH};
	localparam logic [19:0] REG_BLANK  = {BLANK_CH, BLANK_CH, BLANK_CH, BLANK_CH, BLANK_CH};

	// Maps a five-bit segment pattern to its digit; any other pattern is blank.
	function automatic char_t seg_to_char(input logic [4:0] code);
		char_t ch;
		case (code)
			5'd21: ch = 4'd0;
			5'd3:  ch = 4'd1;
			5'd25: ch = 4'd2;
			5'd27: ch = 4'd3;
			5'd15: ch = 4'd4;
			5'd30: ch = 4'd5;
			5'd28: ch = 4'd6;
			5'd19: ch = 4'd7;
			5'd29: ch = 4'd8;
			5'd31: ch = 4'd9;
			default: ch = BLANK_CH;
		endcase
		return ch;
	endfunction

	// A set sign bit forces the relay's sign; a clear one blanks it only if it shows that sign.
	function automatic sign_t upd_sign(input sign_t cur, input logic set, input sign_t which);
		sign_t nxt;
		if (set) begin
			nxt = which;
		end else if (cur == which) begin
			nxt = SIGN_BLANK;
		end else begin
			nxt = cur;
		end
		return nxt;
	endfunction

endpackage

/* rtl/dsky_relay_word_display_decoder.sv */
// Display relay word decoder. Each input transfer carries one relay word that has
// already been split into its relay select (in tuser), a sign bit and two five-bit
// segment codes (in tdata). The segment codes are turned into digits 0-9, or blank
// (15) for any pattern that is not a digit, and the relay select decides which of
// the program, verb and noun digit pairs or which register digits receive them;
// the register relays except R1_TOP and R2R3 also set or clear their register's
// sign. Every input gives exactly one output transfer: a shown flag in tuser (clear
// for the lamp relay and unused relay numbers, which leave the display alone) and
// the complete display state after the update in tdata. An item is captured into
// an input register, decoded by a single level of lookup and selection logic, and
// lands in the output register; one item is taken per cycle as long as the output
// side keeps accepting. The held display state is updated in the same cycle the
// item moves into the output register, so a stall on the output side simply holds
// the input register and back-pressures the input.
// Reset blanks every digit and sign.
module dsky_relay_word_display_decoder
	import dsky_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Bits from the lowest: sign_bit[0], left_code[5:1], right_code[10:6], zero fill.
	input  logic [15:0] s_axis_tdata,
	// Bits from the lowest: relay_select[3:0].
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Bits from the lowest: prog_digits[7:0], verb_digits[15:8], noun_digits[23:16],
	// reg1_sign[25:24], reg1_digits[45:26], reg2_sign[47:46], reg2_digits[67:48],
	// reg3_sign[69:68], reg3_digits[89:70], zero fill.
	output logic [95:0] m_axis_tdata,
	// Bits from the lowest: shown[0].
	output logic [0:0]  m_axis_tuser
);

	// Input register.
	logic        valid_s1;
	relay_t      relay_s1;
	logic        sign_bit_s1;
	logic [4:0]  left_code_s1;
	logic [4:0]  right_code_s1;

	// Held display state.
	logic [7:0]  prog_q, verb_q, noun_q;
	sign_t       reg1_sign_q, reg2_sign_q, reg3_sign_q;
	logic [19:0] reg1_q, reg2_q, reg3_q;

	// Output register.
	logic        out_valid_q;
	logic [95:0] out_data_q;
	logic        out_shown_q;

	// Next display state and shown flag for the item in the input register.
	logic [7:0]  prog_d, verb_d, noun_d;
	sign_t       reg1_sign_d, reg2_sign_d, reg3_sign_d;
	logic [19:0] reg1_d, reg2_d, reg3_d;
	logic        shown_d;
	char_t       lc, rc;

	logic        advance;
	logic        take_in;

	// The item in the input register moves on when the output register is empty or
	// is being emptied in this cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			relay_s1      <= s_axis_tuser;
			sign_bit_s1   <= s_axis_tdata[0];
			left_code_s1  <= s_axis_tdata[5:1];
			right_code_s1 <= s_axis_tdata[10:6];
		end
	end

	assign lc = seg_to_char(left_code_s1);
	assign rc = seg_to_char(right_code_s1);

	// Register digit positions run from the top nibble (leftmost) down.
	always_comb begin
		prog_d      = prog_q;
		verb_d      = verb_q;
		noun_d      = noun_q;
		reg1_sign_d = reg1_sign_q;
		reg2_sign_d = reg2_sign_q;
		reg3_sign_d = reg3_sign_q;
		reg1_d      = reg1_q;
		reg2_d      = reg2_q;
		reg3_d      = reg3_q;
		shown_d     = 1'b1;
		case (relay_s1)
			RELAY_PROG: prog_d = {lc, rc};
			RELAY_VERB: verb_d = {lc, rc};
			RELAY_NOUN: noun_d = {lc, rc};
			RELAY_R1_TOP: begin
				reg1_d[19:16] = rc;
			end
			RELAY_R1_MID: begin
				reg1_d[15:8] = {lc, rc};
				reg1_sign_d  = upd_sign(reg1_sign_q, sign_bit_s1, SIGN_PLUS);
			end
			RELAY_R1_LO: begin
				reg1_d[7:0] = {lc, rc};
				reg1_sign_d = upd_sign(reg1_sign_q, sign_bit_s1, SIGN_MINUS);
			end
			RELAY_R2_HI: begin
				reg2_d[19:12] = {lc, rc};
				reg2_sign_d   = upd_sign(reg2_sign_q, sign_bit_s1, SIGN_PLUS);
			end
			RELAY_R2_LO: begin
				reg2_d[11:4] = {lc, rc};
				reg2_sign_d  = upd_sign(reg2_sign_q, sign_bit_s1, SIGN_MINUS);
			end
			RELAY_R2R3: begin
				reg2_d[3:0]   = lc;
				reg3_d[19:16] = rc;
			end
			RELAY_R3_HI: begin
				reg3_d[15:8] = {lc, rc};
				reg3_sign_d  = upd_sign(reg3_sign_q, sign_bit_s1, SIGN_PLUS);
			end
			RELAY_R3_LO: begin
				reg3_d[7:0] = {lc, rc};
				reg3_sign_d = upd_sign(reg3_sign_q, sign_bit_s1, SIGN_MINUS);
			end
			default: shown_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q      <= PAIR_BLANK;
			verb_q      <= PAIR_BLANK;
			noun_q      <= PAIR_BLANK;
			reg1_sign_q <= SIGN_BLANK;
			reg2_sign_q <= SIGN_BLANK;
			reg3_sign_q <= SIGN_BLANK;
			reg1_q      <= REG_BLANK;
			reg2_q      <= REG_BLANK;
			reg3_q      <= REG_BLANK;
		end else if (advance) begin
			prog_q      <= prog_d;
			verb_q      <= verb_d;
			noun_q      <= noun_d;
			reg1_sign_q <= reg1_sign_d;
			reg2_sign_q <= reg2_sign_d;
			reg3_sign_q <= reg3_sign_d;
			reg1_q      <= reg1_d;
			reg2_q      <= reg2_d;
			reg3_q      <= reg3_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_shown_q <= shown_d;
			out_data_q  <= {6'd0, reg3_d, reg3_sign_d, reg2_d, reg2_sign_d,
				reg1_d, reg1_sign_d, noun_d, verb_d, prog_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_shown_q;

endmodule

/* rtl/dsky_checker.sv */
`include "dsky_relay_word_display_decoder_macros.svh"

module dsky_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic [3:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	logic m_xfer;
	logic s_xfer;

	assign m_xfer = m_axis_tvalid && m_axis_tready;
	assign s_xfer = s_axis_tvalid && s_axis_tready;

	// A result that is not taken stays offered.
	`DSKY_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output valid dropped while stalled")

	// A stalled result keeps its payload.
	`DSKY_ASSERT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "output payload changed while stalled")

	// No register sign ever takes the unused code.
	`DSKY_ASSERT(a_sign_legal, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[25:24] != 2'd3 && m_axis_tdata[47:46] != 2'd3 && m_axis_tdata[69:68] != 2'd3, "illegal sign code")

	// A result that was not shown repeats the display of the result just before it.
	`DSKY_ASSERT(a_unshown_keeps, clk, arst_n, m_xfer ##1 (m_xfer && !m_axis_tuser[0]) |-> m_axis_tdata == $past(m_axis_tdata), "display changed by a relay that is not shown")

	// With reset held, no result is offered.
	`DSKY_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n && $past(!arst_n) |-> !m_axis_tvalid && !$past(s_xfer && m_xfer), "output active during reset")

endmodule

bind dsky_relay_word_display_decoder dsky_checker u_dsky_checker (.*);
